>>> design/value_noise_fbm_texel_core_macros.svh
// assertion macros for the value noise texel core
// used by the top level only, no other dependencies
`ifndef VALUE_NOISE_FBM_TEXEL_CORE_MACROS_SVH
`define VALUE_NOISE_FBM_TEXEL_CORE_MACROS_SVH

// same-cycle implication, ignored while in reset
`define VNF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication, also checked across reset
`define VNF_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/vnf_pkg.sv
// shared types, constants and helpers for the value noise texel core
// no dependencies
`default_nettype none
package vnf_pkg;

  localparam int unsigned TEX_SIDE        = 1024;
  localparam int unsigned MAX_OCTAVES_DEF = 8;
  localparam int unsigned PW              = 26;   // lattice position, Q10.16
  localparam int unsigned VW              = 17;   // octave sum, up to one in Q.16

  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] MIX_C1  = 32'h7feb352d;
  localparam logic [31:0] MIX_C2  = 32'h846ca68b;

  localparam logic [3:0] OCT_RESET   = 4'd5;
  localparam logic [15:0] SCALE_RESET = 16'd2621;

  typedef enum logic [3:0] {
    REG_OCTAVE_COUNT = 4'd0,
    REG_COORD_SCALE  = 4'd1
  } reg_index_t;

  // word handed from stage to stage between the modules
  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [3:0]    n;
    logic [VW-1:0] v;
  } vnf_word_t;

  localparam int unsigned WRAP_SH    = 21;
  localparam int unsigned WRAP_RECIP = ((2 ** WRAP_SH) + TEX_SIDE - 1) / TEX_SIDE;

  // coordinate modulo the texture side, reciprocal multiply plus one correction
  function automatic logic [9:0] wrap_coord(input logic [9:0] c);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(c) * 32'(WRAP_RECIP)) >> WRAP_SH;
    r = 32'(c) - q * 32'(TEX_SIDE);
    if (r >= 32'(TEX_SIDE)) begin
      r = r - 32'(TEX_SIDE);
    end
    if (TEX_SIDE >= 1024) begin
      r = 32'(c);
    end
    return r[9:0];
  endfunction

endpackage
`default_nettype wire

>>> design/vnf_front.sv
// input stage: coordinate wrap, scale multiply and octave clamp
// depends on vnf_pkg
`default_nettype none
module vnf_front #(
  parameter int unsigned MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic [9:0]       x_coord,
  input  wire logic [9:0]       y_coord,
  input  wire logic [3:0]       octave_count,
  input  wire logic [15:0]      coord_scale,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output vnf_pkg::vnf_word_t    dn_word
);
  import vnf_pkg::*;

  logic vld;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_word.px <= PW'(wrap_coord(x_coord)) * PW'(coord_scale);
      dn_word.py <= PW'(wrap_coord(y_coord)) * PW'(coord_scale);
      dn_word.n  <= (octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octave_count;
      dn_word.v  <= '0;
    end
  end

endmodule
`default_nettype wire

>>> design/vnf_octave.sv
// one noise octave in six stages: lattice products, two hash mix rounds,
// x lerp, y lerp, accumulate; depends on vnf_pkg
`default_nettype none
module vnf_octave #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  vnf_pkg::vnf_word_t up_word,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output vnf_pkg::vnf_word_t dn_word
);
  import vnf_pkg::*;

  localparam int unsigned NS = 6;
  localparam int unsigned SW = PW + SHIFT;

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  vnf_word_t     w [NS];

  // stage registers
  logic [31:0] ax1, ay1, txx1, tyy1;
  logic [15:0] tx1, ty1;
  logic [31:0] h2 [4];
  logic [16:0] sx2, sy2;
  logic [31:0] h3 [4];
  logic [16:0] sx3, sy3;
  logic [15:0] ab4, cd4;
  logic [16:0] sy4;
  logic [15:0] nz5;

  logic [SW-1:0] sxp, syp;
  logic [31:0]   seed [4];
  logic [15:0]   cv [4];
  logic [33:0]   smx, smy;
  logic [31:0]   lab, lcd, lxy;
  vnf_word_t     w5_next;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];
  assign dn_word  = w[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    sxp = SW'(up_word.px) << SHIFT;
    syp = SW'(up_word.py) << SHIFT;
    for (int c = 0; c < 4; c++) begin
      seed[c] = (ax1 + (c[0] ? HASH_KX : 32'd0)) ^ (ay1 + (c[1] ? HASH_KY : 32'd0));
      seed[c] = seed[c] ^ (seed[c] >> 16);
      cv[c]   = 16'((h3[c] ^ (h3[c] >> 16)) >> 15);
    end
    smx = 34'(txx1[31:16]) * (34'(196608) - 34'({tx1, 1'b0}));
    smy = 34'(tyy1[31:16]) * (34'(196608) - 34'({ty1, 1'b0}));
    lab = 32'(cv[0]) * (32'(65536) - 32'(sx3)) + 32'(cv[1]) * 32'(sx3);
    lcd = 32'(cv[2]) * (32'(65536) - 32'(sx3)) + 32'(cv[3]) * 32'(sx3);
    lxy = 32'(ab4) * (32'(65536) - 32'(sy4)) + 32'(cd4) * 32'(sy4);
    w5_next = w[4];
    // octaves past the configured count add nothing
    if (4'(SHIFT) < w[4].n) begin
      w5_next.v = w[4].v + VW'(nz5 >> (SHIFT + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      w[0] <= up_word;
      ax1  <= 32'(sxp >> 16) * HASH_KX;
      ay1  <= 32'(syp >> 16) * HASH_KY;
      tx1  <= sxp[15:0];
      ty1  <= syp[15:0];
      txx1 <= 32'(sxp[15:0]) * 32'(sxp[15:0]);
      tyy1 <= 32'(syp[15:0]) * 32'(syp[15:0]);
    end
    if (rdy[1]) begin
      w[1] <= w[0];
      for (int c = 0; c < 4; c++) begin
        h2[c] <= seed[c] * MIX_C1;
      end
      sx2 <= 17'(smx >> 16);
      sy2 <= 17'(smy >> 16);
    end
    if (rdy[2]) begin
      w[2] <= w[1];
      for (int c = 0; c < 4; c++) begin
        h3[c] <= (h2[c] ^ (h2[c] >> 15)) * MIX_C2;
      end
      sx3 <= sx2;
      sy3 <= sy2;
    end
    if (rdy[3]) begin
      w[3] <= w[2];
      ab4  <= lab[31:16];
      cd4  <= lcd[31:16];
      sy4  <= sy3;
    end
    if (rdy[4]) begin
      w[4] <= w[3];
      nz5  <= lxy[31:16];
    end
    if (rdy[5]) begin
      w[5] <= w5_next;
    end
  end

endmodule
`default_nettype wire

>>> design/vnf_back.sv
// output stage: clamp to one, scale to a byte with rounding, output register
// depends on vnf_pkg
`default_nettype none
module vnf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  vnf_pkg::vnf_word_t up_word,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         gray_level
);
  import vnf_pkg::*;

  logic [VW-1:0] vc;
  logic [24:0]   scaled;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    vc     = (up_word.v > VW'(65536)) ? VW'(65536) : up_word.v;
    scaled = 25'(vc) * 25'(255) + 25'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      gray_level <= scaled[23:16];
    end
  end

endmodule
`default_nettype wire

>>> design/value_noise_fbm_texel_core.sv
// value noise fbm texel core, top level: config registers and the stage chain
// depends on vnf_pkg, vnf_front, vnf_octave, vnf_back and the macros header
//
//  channel  dir  signals                                   word
//  in       in   in_valid in_ready x_coord y_coord         one texel
//  out      out  out_valid out_ready gray_level            one gray byte
//  cfg      in   cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// one texel per clock while out_ready holds; six stages per octave unit
// (lattice products, four hash multiplies in two rounds, x lerp, y lerp,
// accumulate) lie between the front and output registers. rst clears all valid
// bits and loads five octaves and scale 2621. every stage holds while its
// successor is full, and empty stages fill up: no word is dropped or repeated.
`default_nettype none
`include "value_noise_fbm_texel_core_macros.svh"
module value_noise_fbm_texel_core #(
  parameter int unsigned MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  x_coord,
  input  wire logic [9:0]  y_coord,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       gray_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import vnf_pkg::*;

  logic [3:0]  octave_count_q;
  logic [15:0] coord_scale_q;

  logic      vl [MAX_OCTAVES+1];
  logic      rd [MAX_OCTAVES+1];
  vnf_word_t wd [MAX_OCTAVES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count_q <= OCT_RESET;
      coord_scale_q  <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OCTAVE_COUNT: octave_count_q <= cfg_data[3:0];
        REG_COORD_SCALE:  coord_scale_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  vnf_front #(.MAX_OCTAVES(MAX_OCTAVES)) u_front (
    .clk, .rst,
    .up_valid(in_valid), .up_ready(in_ready),
    .x_coord, .y_coord,
    .octave_count(octave_count_q), .coord_scale(coord_scale_q),
    .dn_valid(vl[0]), .dn_ready(rd[0]), .dn_word(wd[0])
  );

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    vnf_octave #(.SHIFT(i)) u_oct (
      .clk, .rst,
      .up_valid(vl[i]), .up_ready(rd[i]), .up_word(wd[i]),
      .dn_valid(vl[i+1]), .dn_ready(rd[i+1]), .dn_word(wd[i+1])
    );
  end

  vnf_back u_back (
    .clk, .rst,
    .up_valid(vl[MAX_OCTAVES]), .up_ready(rd[MAX_OCTAVES]), .up_word(wd[MAX_OCTAVES]),
    .out_valid, .out_ready, .gray_level
  );

  // an empty or draining output means the whole chain can take a word
  `VNF_ASSERT_IMPLY(a_empty_takes, clk, rst, !out_valid, in_ready)
  `VNF_ASSERT_IMPLY(a_drain_takes, clk, rst, out_ready, in_ready)
  `VNF_ASSERT_NEXT(a_reset_regs, clk, rst, (octave_count_q == OCT_RESET) && (coord_scale_q == SCALE_RESET))

endmodule
`default_nettype wire
